@@ rtl/ppf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse phase folder package
// Shared widths, request and register codes, transfer payload types and
// the sample squaring function.
// ----------------------------------------------------------------------------
package ppf_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SEL_W      = 8;
  localparam int unsigned POL_W      = 20;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SQ_W       = 39;
  localparam int unsigned POWER_W    = 41;
  localparam int unsigned NUM_BINS_W = 9;
  localparam int unsigned BIN_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CHAN_CODES = 2 ** CHAN_W;
  localparam int unsigned SEL_CODES  = 2 ** SEL_W;
  localparam int unsigned OUT_DEPTH  = 8;
  localparam int unsigned OUT_PTR_W  = 3;
  localparam int unsigned OUT_CNT_W  = 4;

  localparam logic [NUM_BINS_W-1:0] NUM_BINS_RST   = 9'd256;
  localparam logic [PHASE_W-1:0]    PHASE_STEP_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BINS   = 1'b0,
    CFG_PHASE_STEP = 1'b1
  } cfg_idx_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_FOLD    = 2'd0,
    REQ_LOAD    = 2'd1,
    REQ_PRELOAD = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  typedef struct packed {
    req_e                       req_type;
    logic [CHAN_W-1:0]          channel;
    logic [SEL_W-1:0]           bin_sel;
    logic signed [POL_W-1:0]    pol0_re;
    logic signed [POL_W-1:0]    pol0_im;
    logic signed [POL_W-1:0]    pol1_re;
    logic signed [POL_W-1:0]    pol1_im;
    logic [PHASE_W-1:0]         start_phase;
    logic [SUM_W-1:0]           preload_sum;
  } in_item_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [SUM_W-1:0]     bin_sum;
    logic [CNT_W-1:0]     bin_count;
    logic                 saturated;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    req_e               req;
    logic [POWER_W-1:0] power;
    logic [SUM_W-1:0]   preload_sum;
  } stage_t;

  function automatic logic [SQ_W-1:0] square(input logic signed [POL_W-1:0] x);
    logic signed [2*POL_W-1:0] p;
    p = x * x;
    return p[SQ_W-1:0];
  endfunction

endpackage

@@ rtl/ppf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse phase folder RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ppf_phase.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse phase folder phase stage
// Channel phase store with read-modify-write, bin selection from phase and
// bin count (folds) or bin select (others), and Stokes I sample power.
// ----------------------------------------------------------------------------
module ppf_phase #(
  parameter int unsigned CHANNELS = 256,
  parameter int unsigned MAX_BINS = 256,
  localparam int unsigned CH_AW  = $clog2(CHANNELS),
  localparam int unsigned BIN_AW = $clog2(MAX_BINS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  ppf_pkg::in_item_t                   in_data_i,
  input  logic [ppf_pkg::NUM_BINS_W-1:0]      num_bins_i,
  input  logic [ppf_pkg::PHASE_W-1:0]         phase_step_i,
  output logic                                s1_vld_o,
  output ppf_pkg::stage_t                     s2_o,
  output logic [BIN_AW-1:0]                   s2_bin_o,
  output logic                                busy_o
);

  localparam int unsigned NB_W   = $clog2(MAX_BINS + 1);
  localparam int unsigned PROD_W = ppf_pkg::PHASE_W + NB_W;

  logic [CH_AW-1:0]  ch_map  [ppf_pkg::CHAN_CODES];
  logic [BIN_AW-1:0] sel_map [ppf_pkg::SEL_CODES];

  for (genvar g = 0; g < ppf_pkg::CHAN_CODES; g++) begin : g_ch_map
    assign ch_map[g] = CH_AW'(g % CHANNELS);
  end

  for (genvar g = 0; g < ppf_pkg::SEL_CODES; g++) begin : g_sel_map
    assign sel_map[g] = BIN_AW'(g % MAX_BINS);
  end

  logic                          clr_busy_q;
  logic [CH_AW-1:0]              clr_addr_q;

  logic                          s1_vld_q;
  ppf_pkg::req_e                 s1_req_q;
  logic [CH_AW-1:0]              s1_ch_q;
  logic [BIN_AW-1:0]             s1_sel_q;
  logic [ppf_pkg::PHASE_W-1:0]   s1_start_q;
  logic [ppf_pkg::SUM_W-1:0]     s1_preload_q;
  logic [3:0][ppf_pkg::SQ_W-1:0] s1_sq_q;

  logic                          pfw_vld_q;
  logic [CH_AW-1:0]              pfw_addr_q;
  logic [ppf_pkg::PHASE_W-1:0]   pfw_data_q;

  ppf_pkg::stage_t               s2_q;
  ppf_pkg::stage_t               s2_d;
  logic [BIN_AW-1:0]             s2_bin_q;
  logic [BIN_AW-1:0]             s2_bin_d;

  logic [ppf_pkg::PHASE_W-1:0]   ram_rdata;
  logic [ppf_pkg::PHASE_W-1:0]   phase_cur;
  logic [ppf_pkg::PHASE_W-1:0]   phase_nxt;
  logic                          phase_wr;
  logic                          ram_we;
  logic [CH_AW-1:0]              ram_waddr;
  logic [ppf_pkg::PHASE_W-1:0]   ram_wdata;
  logic [NB_W-1:0]               nb;
  logic [PROD_W-1:0]             prod;
  logic [ppf_pkg::POWER_W-1:0]   power;

  // clearing pass over the phase store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == CH_AW'(CHANNELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      pfw_vld_q <= 1'b0;
      s2_q      <= '0;
    end else begin
      s1_vld_q  <= accept_i;
      pfw_vld_q <= phase_wr;
      s2_q      <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_req_q     <= in_data_i.req_type;
      s1_ch_q      <= ch_map[in_data_i.channel];
      s1_sel_q     <= sel_map[in_data_i.bin_sel];
      s1_start_q   <= in_data_i.start_phase;
      s1_preload_q <= in_data_i.preload_sum;
      s1_sq_q[0]   <= ppf_pkg::square(in_data_i.pol0_re);
      s1_sq_q[1]   <= ppf_pkg::square(in_data_i.pol0_im);
      s1_sq_q[2]   <= ppf_pkg::square(in_data_i.pol1_re);
      s1_sq_q[3]   <= ppf_pkg::square(in_data_i.pol1_im);
    end
    pfw_addr_q <= s1_ch_q;
    pfw_data_q <= phase_nxt;
    s2_bin_q   <= s2_bin_d;
  end

  // forward the phase written in the cycle this item read the store
  assign phase_cur = (pfw_vld_q && (pfw_addr_q == s1_ch_q)) ? pfw_data_q : ram_rdata;

  always_comb begin
    phase_wr  = 1'b0;
    phase_nxt = phase_cur + phase_step_i;
    case (s1_req_q) inside
      ppf_pkg::REQ_FOLD: begin
        phase_wr = s1_vld_q;
      end
      ppf_pkg::REQ_LOAD: begin
        phase_wr  = s1_vld_q;
        phase_nxt = s1_start_q;
      end
      ppf_pkg::REQ_PRELOAD, ppf_pkg::REQ_READ: begin
        phase_wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (num_bins_i == '0) begin
      nb = NB_W'(1);
    end else if (32'(num_bins_i) > MAX_BINS) begin
      nb = NB_W'(MAX_BINS);
    end else begin
      nb = NB_W'(num_bins_i);
    end
  end

  assign prod  = PROD_W'(phase_cur) * PROD_W'(nb);
  assign power = ppf_pkg::POWER_W'(s1_sq_q[0]) + ppf_pkg::POWER_W'(s1_sq_q[1])
               + ppf_pkg::POWER_W'(s1_sq_q[2]) + ppf_pkg::POWER_W'(s1_sq_q[3]);

  always_comb begin
    s2_d.valid       = s1_vld_q;
    s2_d.req         = s1_req_q;
    s2_d.power       = power;
    s2_d.preload_sum = s1_preload_q;
    s2_bin_d         = (s1_req_q == ppf_pkg::REQ_FOLD) ? prod[ppf_pkg::PHASE_W +: BIN_AW]
                                                       : s1_sel_q;
  end

  assign ram_we    = clr_busy_q | phase_wr;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_ch_q;
  assign ram_wdata = clr_busy_q ? '0 : phase_nxt;

  ppf_ram #(
    .WIDTH (ppf_pkg::PHASE_W),
    .DEPTH (CHANNELS)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept_i),
    .raddr_i (ch_map[in_data_i.channel]),
    .rdata_o (ram_rdata)
  );

  assign s1_vld_o = s1_vld_q;
  assign s2_o     = s2_q;
  assign s2_bin_o = s2_bin_q;
  assign busy_o   = clr_busy_q;

endmodule

@@ rtl/ppf_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse phase folder bin accumulator
// Bin sum and count store with saturating read-modify-write, preload and
// read-out of one bin.
// ----------------------------------------------------------------------------
module ppf_accum #(
  parameter int unsigned MAX_BINS = 256,
  localparam int unsigned BIN_AW = $clog2(MAX_BINS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppf_pkg::stage_t    s2_i,
  input  logic [BIN_AW-1:0]  s2_bin_i,
  output logic               res_vld_o,
  output ppf_pkg::out_item_t res_o,
  output logic               busy_o
);

  localparam int unsigned ENT_W = ppf_pkg::SUM_W + ppf_pkg::CNT_W;

  logic                        clr_busy_q;
  logic [BIN_AW-1:0]           clr_addr_q;

  logic                        s3_vld_q;
  ppf_pkg::req_e               s3_req_q;
  logic [BIN_AW-1:0]           s3_bin_q;
  logic [ppf_pkg::POWER_W-1:0] s3_power_q;
  logic [ppf_pkg::SUM_W-1:0]   s3_preload_q;

  logic                        bfw_vld_q;
  logic [BIN_AW-1:0]           bfw_addr_q;
  logic [ENT_W-1:0]            bfw_data_q;

  logic [ENT_W-1:0]            ram_rdata;
  logic [ENT_W-1:0]            cur;
  logic [ppf_pkg::SUM_W-1:0]   cur_sum;
  logic [ppf_pkg::CNT_W-1:0]   cur_cnt;
  logic [ppf_pkg::SUM_W:0]     sum_ext;
  logic [ppf_pkg::SUM_W-1:0]   fold_sum;
  logic [ppf_pkg::CNT_W-1:0]   fold_cnt;
  logic                        bin_wr;
  logic [ppf_pkg::SUM_W-1:0]   new_sum;
  logic [ppf_pkg::CNT_W-1:0]   new_cnt;
  logic [ppf_pkg::BIN_IDX_W-1:0] res_bin;
  logic                        ram_we;
  logic [BIN_AW-1:0]           ram_waddr;
  logic [ENT_W-1:0]            ram_wdata;

  // clearing pass over the bin store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == BIN_AW'(MAX_BINS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q  <= 1'b0;
      bfw_vld_q <= 1'b0;
    end else begin
      s3_vld_q  <= s2_i.valid;
      bfw_vld_q <= s3_vld_q & bin_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_req_q     <= s2_i.req;
    s3_bin_q     <= s2_bin_i;
    s3_power_q   <= s2_i.power;
    s3_preload_q <= s2_i.preload_sum;
    bfw_addr_q   <= s3_bin_q;
    bfw_data_q   <= {new_sum, new_cnt};
  end

  // forward the entry written in the cycle this item read the store
  assign cur     = (bfw_vld_q && (bfw_addr_q == s3_bin_q)) ? bfw_data_q : ram_rdata;
  assign cur_sum = cur[ENT_W-1 -: ppf_pkg::SUM_W];
  assign cur_cnt = cur[ppf_pkg::CNT_W-1:0];

  assign sum_ext  = {1'b0, cur_sum} + (ppf_pkg::SUM_W + 1)'(s3_power_q);
  assign fold_sum = sum_ext[ppf_pkg::SUM_W] ? '1 : sum_ext[ppf_pkg::SUM_W-1:0];
  assign fold_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;

  always_comb begin
    bin_wr  = 1'b0;
    new_sum = cur_sum;
    new_cnt = cur_cnt;
    res_bin = ppf_pkg::BIN_IDX_W'(s3_bin_q);
    case (s3_req_q)
      ppf_pkg::REQ_FOLD: begin
        bin_wr  = 1'b1;
        new_sum = fold_sum;
        new_cnt = fold_cnt;
      end
      ppf_pkg::REQ_PRELOAD: begin
        bin_wr  = 1'b1;
        new_sum = s3_preload_q;
        new_cnt = '0;
      end
      ppf_pkg::REQ_READ: begin
        bin_wr = 1'b0;
      end
      ppf_pkg::REQ_LOAD: begin
        new_sum = '0;
        new_cnt = '0;
        res_bin = '0;
      end
    endcase
  end

  assign ram_we    = clr_busy_q | (s3_vld_q & bin_wr);
  assign ram_waddr = clr_busy_q ? clr_addr_q : s3_bin_q;
  assign ram_wdata = clr_busy_q ? '0 : {new_sum, new_cnt};

  ppf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s2_i.valid),
    .raddr_i (s2_bin_i),
    .rdata_o (ram_rdata)
  );

  assign res_vld_o       = s3_vld_q;
  assign res_o.bin_index = res_bin;
  assign res_o.bin_sum   = new_sum;
  assign res_o.bin_count = new_cnt;
  assign res_o.saturated = (&new_sum) | (&new_cnt);
  assign busy_o          = clr_busy_q;

endmodule

@@ rtl/ppf_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse phase folder output queue
// Small register FIFO that holds finished results until the output
// transfer completes.
// ----------------------------------------------------------------------------
module ppf_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  ppf_pkg::out_item_t              push_data_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output ppf_pkg::out_item_t              data_o,
  output logic [ppf_pkg::OUT_CNT_W-1:0]   count_o
);

  ppf_pkg::out_item_t                 mem_q [ppf_pkg::OUT_DEPTH];
  logic [ppf_pkg::OUT_PTR_W-1:0]      wr_ptr_q;
  logic [ppf_pkg::OUT_PTR_W-1:0]      rd_ptr_q;
  logic [ppf_pkg::OUT_CNT_W-1:0]      count_q;
  logic [ppf_pkg::OUT_CNT_W-1:0]      count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

@@ rtl/pulse_phase_folder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse phase folder unit
// Folds channelised dual-polarisation Stokes I power into pulse phase bins,
// with per-channel phase tracking, bin preload and bin read-out.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while input ready is high. Each
// request passes a three-stage pipeline: the channel phase store is read and
// written back in stage s1, the bin sum and count store is read and written
// back in stage s3, and the result then enters an eight-entry output queue.
// Both stores forward the entry written by the request directly ahead, so
// back-to-back requests to the same channel or bin see each other's updates.
// The output queue and the three pipeline stages share one credit count:
// input ready drops only during the clearing pass or when the queue could
// not hold every request already in flight. After reset a clearing pass
// zeroes both stores, one entry per cycle, and input ready stays low until
// it ends; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module pulse_phase_folder_unit #(
  parameter int unsigned CHANNELS = 256,
  parameter int unsigned MAX_BINS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ppf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ppf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ppf_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ppf_pkg::out_item_t                out_data_o
);

  localparam int unsigned BIN_AW = $clog2(MAX_BINS);

  logic [ppf_pkg::NUM_BINS_W-1:0] num_bins_q;
  logic [ppf_pkg::PHASE_W-1:0]    phase_step_q;

  logic                           accept;
  logic                           s1_vld;
  ppf_pkg::stage_t                s2;
  logic [BIN_AW-1:0]              s2_bin;
  logic                           phase_busy;
  logic                           accum_busy;
  logic                           res_vld;
  ppf_pkg::out_item_t             res;
  logic                           pop;
  logic [ppf_pkg::OUT_CNT_W-1:0]  fifo_cnt;
  logic [ppf_pkg::OUT_CNT_W-1:0]  committed;
  logic                           busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q   <= ppf_pkg::NUM_BINS_RST;
      phase_step_q <= ppf_pkg::PHASE_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (ppf_pkg::cfg_idx_e'(cfg_idx_i))
        ppf_pkg::CFG_NUM_BINS:   num_bins_q   <= cfg_data_i[ppf_pkg::NUM_BINS_W-1:0];
        ppf_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i[ppf_pkg::PHASE_W-1:0];
      endcase
    end
  end

  assign busy      = phase_busy | accum_busy;
  assign committed = fifo_cnt + ppf_pkg::OUT_CNT_W'(s1_vld) + ppf_pkg::OUT_CNT_W'(s2.valid)
                   + ppf_pkg::OUT_CNT_W'(res_vld);
  assign in_ready_o = !busy && (committed < ppf_pkg::OUT_CNT_W'(ppf_pkg::OUT_DEPTH));
  assign accept     = in_valid_i & in_ready_o;
  assign pop        = out_valid_o & out_ready_i;

  ppf_phase #(
    .CHANNELS (CHANNELS),
    .MAX_BINS (MAX_BINS)
  ) u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_data_i    (in_data_i),
    .num_bins_i   (num_bins_q),
    .phase_step_i (phase_step_q),
    .s1_vld_o     (s1_vld),
    .s2_o         (s2),
    .s2_bin_o     (s2_bin),
    .busy_o       (phase_busy)
  );

  ppf_accum #(
    .MAX_BINS (MAX_BINS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s2_i      (s2),
    .s2_bin_i  (s2_bin),
    .res_vld_o (res_vld),
    .res_o     (res),
    .busy_o    (accum_busy)
  );

  ppf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o),
    .count_o     (fifo_cnt)
  );

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 res_vld)
    else $error("accepted request did not reach the output queue");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> (fifo_cnt != ppf_pkg::OUT_CNT_W'(ppf_pkg::OUT_DEPTH)))
    else $error("result pushed into a full output queue");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("clearing pass restarted without reset");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !res_vld) |=> (fifo_cnt == $past(fifo_cnt) - 1'b1))
    else $error("output transfer did not drain the queue");

endmodule
